// ===== hw/rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Constants, opcode and status codes, pipeline types and helpers for the
// complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_W        = 16;
    localparam int OP_W          = 3;
    localparam int ST_W          = 2;
    localparam int FRAC_BITS     = 8;
    localparam int CORDIC_STAGES = 16;

    localparam int PROD_W     = 2 * DATA_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int ABS_W      = DATA_W + 1;
    localparam int DEN_W      = PROD_W;
    localparam int DIV_BITS   = DATA_W + 1;
    localparam int DIV_W      = DEN_W + DIV_BITS;
    localparam int SQ_W       = PROD_W;
    localparam int SQRT_ITERS = SQ_W / 2;
    localparam int ANG_FRAC   = 16;
    localparam int PRE_SHIFT  = 24;
    localparam int CX_W       = ABS_W + PRE_SHIFT + 3;
    localparam int Z_W        = 25;
    localparam int NIT        = (CORDIC_STAGES > DIV_BITS) ? CORDIC_STAGES : DIV_BITS;
    localparam int IDX_W      = $clog2(NIT);

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_MAG   = 3'd4,
        OP_PHASE = 3'd5
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     ovf;
    } t_sat;

    // State carried through the iteration stages
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] pre_re;
        logic signed [DATA_W-1:0] pre_im;
        logic                     pre_sat;
        logic                     den_zero;
        logic                     ovf_re;
        logic                     ovf_im;
        logic                     neg_re;
        logic                     neg_im;
        logic [DEN_W-1:0]         den;
        logic [DIV_W-1:0]         rem_re;
        logic [DIV_W-1:0]         rem_im;
        logic [DIV_BITS-1:0]      q_re;
        logic [DIV_BITS-1:0]      q_im;
        logic [SQ_W-1:0]          sq_n;
        logic [SQ_W-1:0]          sq_r;
        logic signed [CX_W-1:0]   cx;
        logic signed [CX_W-1:0]   cy;
        logic signed [Z_W-1:0]    cz;
        logic                     axis;
    } t_iter;

    function automatic t_sat sat16(input logic signed [63:0] v);
        t_sat s;
        s.ovf = 1'b0;
        if (v > 64'sd32767) begin
            s.val = 16'sh7fff;
            s.ovf = 1'b1;
        end else if (v < -64'sd32768) begin
            s.val = 16'sh8000;
            s.ovf = 1'b1;
        end else begin
            s.val = v[DATA_W-1:0];
        end
        return s;
    endfunction

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [IDX_W-1:0] i);
        int v;
        unique case (int'(i))
            0:  v = 2949120;
            1:  v = 1740967;
            2:  v = 919879;
            3:  v = 466945;
            4:  v = 234379;
            5:  v = 117304;
            6:  v = 58666;
            7:  v = 29335;
            8:  v = 14668;
            9:  v = 7334;
            10: v = 3667;
            11: v = 1833;
            12: v = 917;
            13: v = 458;
            14: v = 229;
            15: v = 115;
            16: v = 57;
            17: v = 29;
            18: v = 14;
            19: v = 7;
            20: v = 4;
            21: v = 2;
            22: v = 1;
            default: v = 0;
        endcase
        return Z_W'(v);
    endfunction

endpackage

// ===== hw/rtl/cau_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_req_if / cau_res_if
// Valid/ready channels for requests and results of the complex ALU.
// ----------------------------------------------------------------------------
interface cau_req_if;
    logic                              valid;
    logic                              ready;
    logic [cau_pkg::OP_W-1:0]          req_type;
    logic signed [cau_pkg::DATA_W-1:0] a_re;
    logic signed [cau_pkg::DATA_W-1:0] a_im;
    logic signed [cau_pkg::DATA_W-1:0] b_re;
    logic signed [cau_pkg::DATA_W-1:0] b_im;

    modport source (output valid, req_type, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [cau_pkg::DATA_W-1:0] res_re;
    logic signed [cau_pkg::DATA_W-1:0] res_im;
    logic [cau_pkg::ST_W-1:0]          status;

    modport source (output valid, res_re, res_im, status, input ready);
    modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

// ===== hw/rtl/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Fixed-point complex ALU: add, subtract, multiply, divide, magnitude and
// phase on signed Q8.8 operands, saturating results.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns one result per request, in order.
// A request passes 21 register stages: input, product and sum stages, 17
// iteration stages set by the 17 quotient bits of the dividers, then the
// output register. Every operation walks the same pipeline; a held result
// stalls the whole pipeline, which keeps accepting while the output is free.
module complex_arithmetic_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_req_if.sink   i_req,
    cau_res_if.source o_res
);
    import cau_pkg::*;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } t_in;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ABS_W-1:0]         abs_re;
        logic [ABS_W-1:0]         abs_im;
        logic                     axis;
        logic signed [DATA_W-1:0] as_re;
        logic signed [DATA_W-1:0] as_im;
        logic                     as_sat;
        logic signed [PROD_W-1:0] arbr;
        logic signed [PROD_W-1:0] aibi;
        logic signed [PROD_W-1:0] aibr;
        logic signed [PROD_W-1:0] arbi;
        logic signed [PROD_W-1:0] brbr;
        logic signed [PROD_W-1:0] bibi;
        logic signed [PROD_W-1:0] arar;
        logic signed [PROD_W-1:0] aiai;
    } t_prod;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ABS_W-1:0]         abs_re;
        logic [ABS_W-1:0]         abs_im;
        logic                     axis;
        logic signed [DATA_W-1:0] as_re;
        logic signed [DATA_W-1:0] as_im;
        logic                     as_sat;
        logic signed [SUM_W-1:0]  mre;
        logic signed [SUM_W-1:0]  mim;
        logic signed [SUM_W-1:0]  nre;
        logic signed [SUM_W-1:0]  nim;
        logic [DEN_W-1:0]         den;
        logic [SQ_W-1:0]          sq;
    } t_sums;

    logic en;
    logic r_a_valid, r_b_valid, r_c_valid;
    t_in   r_a;
    t_prod r_b, n_b;
    t_sums r_c, n_c;

    t_iter          w_stage [NIT+1];
    logic [NIT:0]   w_valid;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_re, n_out_re;
    logic signed [DATA_W-1:0] r_out_im, n_out_im;
    logic [ST_W-1:0]          r_out_st, n_out_st;

    assign en          = !r_out_valid || o_res.ready;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_req.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= '{op: i_req.req_type, a_re: i_req.a_re, a_im: i_req.a_im,
                     b_re: i_req.b_re, b_im: i_req.b_im};
            r_b <= n_b;
            r_c <= n_c;
        end
    end

    // products, absolute values, add and subtract
    logic signed [ABS_W-1:0] ext_re, ext_im, s_re, s_im;
    t_sat                    sat_re, sat_im;

    always_comb begin
        ext_re = ABS_W'(r_a.a_re);
        ext_im = ABS_W'(r_a.a_im);
        if (r_a.op == OP_SUB) begin
            s_re = ABS_W'(r_a.a_re) - ABS_W'(r_a.b_re);
            s_im = ABS_W'(r_a.a_im) - ABS_W'(r_a.b_im);
        end else begin
            s_re = ABS_W'(r_a.a_re) + ABS_W'(r_a.b_re);
            s_im = ABS_W'(r_a.a_im) + ABS_W'(r_a.b_im);
        end
        sat_re = sat16(64'(s_re));
        sat_im = sat16(64'(s_im));

        n_b.op     = r_a.op;
        n_b.abs_re = ext_re[ABS_W-1] ? ABS_W'(-ext_re) : ABS_W'(ext_re);
        n_b.abs_im = ext_im[ABS_W-1] ? ABS_W'(-ext_im) : ABS_W'(ext_im);
        n_b.axis   = (r_a.a_re == '0) && (r_a.a_im != '0);
        n_b.as_re  = sat_re.val;
        n_b.as_im  = sat_im.val;
        n_b.as_sat = sat_re.ovf || sat_im.ovf;
        n_b.arbr   = r_a.a_re * r_a.b_re;
        n_b.aibi   = r_a.a_im * r_a.b_im;
        n_b.aibr   = r_a.a_im * r_a.b_re;
        n_b.arbi   = r_a.a_re * r_a.b_im;
        n_b.brbr   = r_a.b_re * r_a.b_re;
        n_b.bibi   = r_a.b_im * r_a.b_im;
        n_b.arar   = r_a.a_re * r_a.a_re;
        n_b.aiai   = r_a.a_im * r_a.a_im;
    end

    always_comb begin
        n_c.op     = r_b.op;
        n_c.abs_re = r_b.abs_re;
        n_c.abs_im = r_b.abs_im;
        n_c.axis   = r_b.axis;
        n_c.as_re  = r_b.as_re;
        n_c.as_im  = r_b.as_im;
        n_c.as_sat = r_b.as_sat;
        n_c.mre    = SUM_W'(r_b.arbr) - SUM_W'(r_b.aibi);
        n_c.mim    = SUM_W'(r_b.aibr) + SUM_W'(r_b.arbi);
        n_c.nre    = SUM_W'(r_b.arbr) + SUM_W'(r_b.aibi);
        n_c.nim    = SUM_W'(r_b.aibr) - SUM_W'(r_b.arbi);
        n_c.den    = DEN_W'(r_b.brbr) + DEN_W'(r_b.bibi);
        n_c.sq     = SQ_W'(r_b.arar) + SQ_W'(r_b.aiai);
    end

    // set up the iteration state
    logic signed [63:0]      rnd_re, rnd_im;
    t_sat                    ms_re, ms_im;
    logic [SUM_W-1:0]        mag_re, mag_im;
    logic [DIV_W-1:0]        dvd_re, dvd_im, dlim;

    always_comb begin
        rnd_re = (64'(r_c.mre) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        rnd_im = (64'(r_c.mim) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        ms_re  = sat16(rnd_re);
        ms_im  = sat16(rnd_im);
        mag_re = r_c.nre[SUM_W-1] ? SUM_W'(-r_c.nre) : SUM_W'(r_c.nre);
        mag_im = r_c.nim[SUM_W-1] ? SUM_W'(-r_c.nim) : SUM_W'(r_c.nim);
        // rounding to nearest: half the divisor joins the dividend
        dvd_re = (DIV_W'(mag_re[DEN_W-1:0]) << FRAC_BITS) + DIV_W'(r_c.den >> 1);
        dvd_im = (DIV_W'(mag_im[DEN_W-1:0]) << FRAC_BITS) + DIV_W'(r_c.den >> 1);
        dlim   = DIV_W'(r_c.den) << DIV_BITS;

        w_stage[0].op       = r_c.op;
        if (r_c.op == OP_MUL) begin
            w_stage[0].pre_re  = ms_re.val;
            w_stage[0].pre_im  = ms_im.val;
            w_stage[0].pre_sat = ms_re.ovf || ms_im.ovf;
        end else begin
            w_stage[0].pre_re  = r_c.as_re;
            w_stage[0].pre_im  = r_c.as_im;
            w_stage[0].pre_sat = r_c.as_sat;
        end
        w_stage[0].den_zero = (r_c.den == '0);
        w_stage[0].ovf_re   = (dvd_re >= dlim);
        w_stage[0].ovf_im   = (dvd_im >= dlim);
        w_stage[0].neg_re   = r_c.nre[SUM_W-1];
        w_stage[0].neg_im   = r_c.nim[SUM_W-1];
        w_stage[0].den      = r_c.den;
        w_stage[0].rem_re   = dvd_re;
        w_stage[0].rem_im   = dvd_im;
        w_stage[0].q_re     = '0;
        w_stage[0].q_im     = '0;
        w_stage[0].sq_n     = r_c.sq;
        w_stage[0].sq_r     = '0;
        w_stage[0].cx       = $signed(CX_W'(r_c.abs_re) << PRE_SHIFT);
        w_stage[0].cy       = $signed(CX_W'(r_c.abs_im) << PRE_SHIFT);
        w_stage[0].cz       = '0;
        w_stage[0].axis     = r_c.axis;
    end

    assign w_valid[0] = r_c_valid;

    for (genvar g = 0; g < NIT; g++) begin : g_iter
        cau_iter u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_idx   (IDX_W'(g)),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    // finish: rounding, signs, saturation and selection
    t_iter                 fin;
    logic signed [63:0]    q64_re, q64_im, root64, ph64;
    logic signed [Z_W-1:0] zc;
    t_sat                  dq_re, dq_im, rs, ps;

    always_comb begin
        fin    = w_stage[NIT];
        q64_re = fin.ovf_re ? (64'sd1 <<< 40) : 64'(fin.q_re);
        q64_im = fin.ovf_im ? (64'sd1 <<< 40) : 64'(fin.q_im);
        if (fin.neg_re) begin
            q64_re = -q64_re;
        end
        if (fin.neg_im) begin
            q64_im = -q64_im;
        end
        dq_re  = sat16(q64_re);
        dq_im  = sat16(q64_im);

        // remainder above the root means the root rounds up
        root64 = 64'(fin.sq_r) + ((fin.sq_n > fin.sq_r) ? 64'sd1 : 64'sd0);
        rs     = sat16(root64);

        zc     = (fin.cz < 0) ? '0 : fin.cz;
        ph64   = (64'(zc) + (64'sd1 <<< (ANG_FRAC - FRAC_BITS - 1)))
                 >>> (ANG_FRAC - FRAC_BITS);
        if (fin.axis) begin
            ph64 = 64'sd90 <<< FRAC_BITS;
        end
        ps     = sat16(ph64);

        n_out_re = '0;
        n_out_im = '0;
        n_out_st = ST_OK;
        unique case (fin.op)
            OP_ADD, OP_SUB, OP_MUL: begin
                n_out_re = fin.pre_re;
                n_out_im = fin.pre_im;
                n_out_st = fin.pre_sat ? ST_SAT : ST_OK;
            end
            OP_DIV: begin
                if (fin.den_zero) begin
                    n_out_st = ST_DIV_ZERO;
                end else begin
                    n_out_re = dq_re.val;
                    n_out_im = dq_im.val;
                    n_out_st = (dq_re.ovf || dq_im.ovf) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG: begin
                n_out_re = rs.val;
                n_out_st = rs.ovf ? ST_SAT : ST_OK;
            end
            OP_PHASE: begin
                n_out_re = ps.val;
                n_out_st = ps.ovf ? ST_SAT : ST_OK;
            end
            default: begin
                n_out_st = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_valid[NIT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_re <= n_out_re;
            r_out_im <= n_out_im;
            r_out_st <= n_out_st;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.res_re = r_out_re;
    assign o_res.res_im = r_out_im;
    assign o_res.status = r_out_st;

endmodule

// ===== hw/rtl/cau_iter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_iter
// One registered iteration: a quotient bit of both dividers, a square root
// step and a CORDIC vectoring rotation, each only while the index is in its range.
// ----------------------------------------------------------------------------
module cau_iter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [cau_pkg::IDX_W-1:0] i_idx,
    input  logic                      i_valid,
    input  cau_pkg::t_iter            i_stage,
    output logic                      o_valid,
    output cau_pkg::t_iter            o_stage
);
    import cau_pkg::*;

    t_iter                  n_stage;
    logic [IDX_W-1:0]       sh;
    logic [DIV_W-1:0]       dsub;
    logic [DIV_BITS-1:0]    qbit;
    logic [5:0]             sqsh;
    logic [SQ_W-1:0]        sbit;
    logic [SQ_W:0]          strial;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;

    always_comb begin
        n_stage = i_stage;
        sh      = IDX_W'(DIV_BITS - 1 - int'(i_idx));
        dsub    = DIV_W'(i_stage.den) << sh;
        qbit    = DIV_BITS'(1) << sh;
        sqsh    = 6'(SQ_W - 2 - 2 * int'(i_idx));
        sbit    = SQ_W'(1) << sqsh;
        strial  = {1'b0, i_stage.sq_r} + {1'b0, sbit};
        dx      = i_stage.cy >>> i_idx;
        dy      = i_stage.cx >>> i_idx;

        // restoring division, most significant quotient bit first
        if (int'(i_idx) < DIV_BITS) begin
            if (i_stage.rem_re >= dsub) begin
                n_stage.rem_re = i_stage.rem_re - dsub;
                n_stage.q_re   = i_stage.q_re | qbit;
            end
            if (i_stage.rem_im >= dsub) begin
                n_stage.rem_im = i_stage.rem_im - dsub;
                n_stage.q_im   = i_stage.q_im | qbit;
            end
        end

        if (int'(i_idx) < SQRT_ITERS) begin
            if ({1'b0, i_stage.sq_n} >= strial) begin
                n_stage.sq_n = i_stage.sq_n - strial[SQ_W-1:0];
                n_stage.sq_r = (i_stage.sq_r >> 1) + sbit;
            end else begin
                n_stage.sq_r = i_stage.sq_r >> 1;
            end
        end

        // y equal to zero leaves the vector alone
        if (int'(i_idx) < CORDIC_STAGES) begin
            if (i_stage.cy > 0) begin
                n_stage.cx = i_stage.cx + dx;
                n_stage.cy = i_stage.cy - dy;
                n_stage.cz = i_stage.cz + atan_deg(i_idx);
            end else if (i_stage.cy < 0) begin
                n_stage.cx = i_stage.cx - dx;
                n_stage.cy = i_stage.cy + dy;
                n_stage.cz = i_stage.cz - atan_deg(i_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_stage <= n_stage;
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the complex ALU against a behavioural model of each operation.
// Directed corner cases come first, then random requests. Both channels idle
// at random, with a long result hold-off and a full drain along the way.
// ----------------------------------------------------------------------------
module tb;
    import cau_pkg::*;

    localparam int LATENCY   = 21;
    localparam int WDOG_MAX  = 2000;
    localparam int LONG_HOLD = 150;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [1:0]         st;
    } t_cres;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cau_req_if req ();
    cau_res_if res ();

    complex_arithmetic_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req.sink),
        .o_res  (res.source)
    );

    always #5 i_clk = ~i_clk;

    t_cres expected_q[$];
    int    n_err = 0;
    int    idle_cycles = 0;
    bit    src_idle = 1'b1;
    bit    sink_idle = 1'b1;
    int    hold_off = 0;
    // long hold-off: the tests bump hold_req, the sink catches up in hold_seen
    int    hold_req = 0;
    int    hold_seen = 0;

    // ------------------------------------------------------------ model
    function automatic longint fshr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint sat(longint v, inout bit f);
        if (v > 32767) begin f = 1; return 32767; end
        if (v < -32768) begin f = 1; return -32768; end
        return v;
    endfunction

    function automatic longint rdiv(longint num, longint den);
        longint m;
        longint q;
        m = num < 0 ? -num : num;
        q = ((m << FRAC_BITS) + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint sqrt_near(longint s);
        longint r;
        longint b;
        longint n;
        r = 0;
        b = 64'd1 << 32;
        n = s;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s - r * r > r) r++;
        return r;
    endfunction

    function automatic longint phase_of(longint re, longint im);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
            58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
            14, 7, 4, 2, 1, 0};
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (re < 0) re = -re;
        if (im < 0) im = -im;
        if (re == 0 && im == 0) return 0;
        if (re == 0) return longint'(90) << FRAC_BITS;
        x = re << 24;
        y = im << 24;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += tab[i];
            end else if (y < 0) begin
                x -= dx; y += dy; z -= tab[i];
            end
        end
        if (z < 0) z = 0;
        return fshr(z + (64'sd1 <<< 7), 16 - FRAC_BITS);
    endfunction

    function automatic t_cres alu_result(logic [2:0] op, logic signed [15:0] ar,
                                         logic signed [15:0] ai,
                                         logic signed [15:0] br,
                                         logic signed [15:0] bi);
        t_cres r;
        longint rr;
        longint ri;
        longint den;
        bit     f;
        rr = 0;
        ri = 0;
        f = 0;
        r.st = ST_OK;
        case (op)
            OP_ADD: begin
                rr = sat(longint'(ar) + br, f); ri = sat(longint'(ai) + bi, f);
            end
            OP_SUB: begin
                rr = sat(longint'(ar) - br, f); ri = sat(longint'(ai) - bi, f);
            end
            OP_MUL: begin
                rr = sat(fshr(longint'(ar) * br - longint'(ai) * bi + 128, FRAC_BITS), f);
                ri = sat(fshr(longint'(ai) * br + longint'(ar) * bi + 128, FRAC_BITS), f);
            end
            OP_DIV: begin
                den = longint'(br) * br + longint'(bi) * bi;
                if (den == 0) begin
                    r.st = ST_DIV_ZERO;
                end else begin
                    rr = sat(rdiv(longint'(ar) * br + longint'(ai) * bi, den), f);
                    ri = sat(rdiv(longint'(ai) * br - longint'(ar) * bi, den), f);
                end
            end
            OP_MAG:   rr = sat(sqrt_near(longint'(ar) * ar + longint'(ai) * ai), f);
            OP_PHASE: rr = sat(phase_of(ar, ai), f);
            default: ;
        endcase
        if (f && r.st == ST_OK) r.st = ST_SAT;
        r.re = rr[15:0];
        r.im = ri[15:0];
        return r;
    endfunction

    // ------------------------------------------------------------ driving
    task automatic send_req(logic [2:0] op, logic [15:0] ar, logic [15:0] ai,
                            logic [15:0] br, logic [15:0] bi);
        int gap;
        if (!src_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.req_type <= op;
        req.a_re <= ar;
        req.a_im <= ai;
        req.b_re <= br;
        req.b_im <= bi;
        expected_q.push_back(alu_result(op, ar, ai, br, bi));
        do @(posedge i_clk); while (!req.ready);
    endtask

    task automatic stop_req();
        req.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------ sink side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_off <= LONG_HOLD - 1;
            res.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            res.ready <= 1'b0;
        end else if (!sink_idle && $urandom_range(0, 7) == 0) begin
            hold_off <= $urandom_range(1, 9) - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cres e;
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result re=%0d im=%0d st=%0d",
                                          res.res_re, res.res_im, res.status);
            end else begin
                e = expected_q.pop_front();
                if (res.res_re !== e.re || res.res_im !== e.im || res.status !== e.st) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                                 e.re, e.im, e.st, res.res_re, res.res_im, res.status);
                end
            end
        end
    end

    // watchdog: cycles with no request or result moving
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------ tests
    task automatic test_directed();
        logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        for (int op = 0; op < 8; op++) begin
            send_req(op[2:0], 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
            send_req(op[2:0], 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
        end
        send_req(OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
        send_req(OP_PHASE, 16'h0000, 16'hfe00, 16'h0, 16'h0);
        send_req(OP_PHASE, 16'h0000, 16'h0000, 16'h0, 16'h0);
        send_req(OP_PHASE, 16'hff00, 16'h0100, 16'h0, 16'h0);
        for (int i = 0; i < 4; i++)
            send_req(OP_MAG, ext[i], ext[3 - i], 16'h0, 16'h0);
        stop_req();
    endtask

    task automatic test_random(int n);
        logic [2:0] op;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
            send_req(op, rnd16(), rnd16(), rnd16(), rnd16());
        end
        stop_req();
    endtask

    // long result hold-off fills the pipeline and must stall the input
    task automatic test_backpressure();
        hold_req++;
        test_random(60);
    endtask

    task automatic wait_drain();
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        req.valid = 1'b0;
        req.req_type = '0;
        req.a_re = '0;
        req.a_im = '0;
        req.b_re = '0;
        req.b_im = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_idle = 1'b0;
        sink_idle = 1'b0;
        test_directed();
        test_random(600);
        test_backpressure();
        wait_drain();
        test_random(700);
        src_idle = 1'b1;
        sink_idle = 1'b1;
        test_random(350);
        wait_drain();
        repeat (LATENCY + 5) @(posedge i_clk);
        if (n_err == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
